// ===== rtl/htif_pkg.sv =====
// ----------------------------------------------------------------------------
// Host-target interface package
// Shared types, codes and constants of the tohost/fromhost mailbox block.
// ----------------------------------------------------------------------------
`default_nettype none

package htif_pkg;

  // Receive queue geometry
  localparam int unsigned RxDepth = 16;
  localparam int unsigned RxAw    = (RxDepth > 1) ? $clog2(RxDepth) : 1;
  localparam int unsigned RxFw    = $clog2(RxDepth + 1);

  // Register window
  localparam logic [11:0] TohostOffset   = 12'd0;
  localparam logic [11:0] FromhostOffset = 12'd8;

  // Only 64-bit accesses are taken
  localparam logic [1:0] AccessSize64 = 2'd3;

  // Poll rate after reset
  localparam logic [19:0] PollDivisorReset = 20'd10;

  // Tohost decode: device and command codes
  localparam logic [7:0] DevSystem  = 8'd0;
  localparam logic [7:0] DevConsole = 8'd1;
  localparam logic [7:0] CmdHalt    = 8'd0;
  localparam logic [7:0] CmdGetchar = 8'd0;
  localparam logic [7:0] CmdPutchar = 8'd1;

  // Fromhost messages
  localparam logic [63:0] PutcharAck = 64'h0101_0000_0000_0000;
  localparam logic [7:0]  RxMsgDev   = 8'h01;

  // Configuration register indexes
  localparam logic [7:0] CfgInteractive = 8'd0;
  localparam logic [7:0] CfgPollDivisor = 8'd1;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_RXBYTE = 2'd3
  } kind_e;

  // Input word, last field in the lowest bits
  typedef struct packed {
    logic [1:0]  pad;
    logic [7:0]  console_byte;
    logic [63:0] write_data;
    logic [1:0]  access_size_log2;
    logic [11:0] offset;
  } in_word_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [3:0]  pad;
    logic        rx_overflow;
    logic [7:0]  char_out;
    logic        char_out_valid;
    logic        halt_request;
    logic        access_ok;
    logic [63:0] read_data;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/host_target_interface_device.sv =====
// ----------------------------------------------------------------------------
// Host-target interface device
// Tohost/fromhost mailbox with console output, halt request and a console
// receive queue held in a synchronous memory that is polled into fromhost.
// ----------------------------------------------------------------------------
// Timing: the result appears in the cycle after its input word is taken.
// Throughput: one word per cycle unless results stall; the queue memory's
// registered read port always prefetches the head, with write forwarding.
// Reset: all control state, the mailbox registers and the config registers
// clear at once (poll divisor to 10); queue entries are never read unwritten.
`default_nettype none

module host_target_interface_device (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: offset[11:0], access_size_log2[13:12], write_data[77:14],
  //        console_byte[85:78], zero fill[87:86]
  input  wire logic [87:0] s_axis_tdata,
  // tuser: kind[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // Result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: read_data[63:0], access_ok[64], halt_request[65],
  //        char_out_valid[66], char_out[74:67], rx_overflow[75], zero fill[79:76]
  output logic [79:0]      m_axis_tdata,
  // Configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int unsigned RxDepth = htif_pkg::RxDepth;
  localparam int unsigned RxAw    = htif_pkg::RxAw;
  localparam int unsigned RxFw    = htif_pkg::RxFw;
  localparam logic [RxAw-1:0] RxLast = RxAw'(RxDepth - 1);
  localparam logic [RxFw-1:0] RxFull = RxFw'(RxDepth);

  htif_pkg::in_word_t  in_word;
  htif_pkg::out_word_t res_d, res_q;
  htif_pkg::kind_e     kind;

  logic        in_acc;
  logic        out_valid_q;
  logic        interactive_q;
  logic [19:0] poll_div_q;
  logic [63:0] tohost_q, tohost_d;
  logic [63:0] fromhost_q, fromhost_d;
  logic        pending_q, pending_d;
  logic        halted_q, halted_d;
  logic [19:0] tick_q, tick_d;
  logic [RxAw-1:0] head_q, head_d, tail_q, tail_d;
  logic [RxFw-1:0] fill_q, fill_d;

  // Queue memory and its registered head read port
  logic [7:0]      rx_mem [RxDepth];
  logic [7:0]      head_byte_q;
  logic            push, pop;

  logic            addr_ok, hit_to, hit_from;
  logic [7:0]      dev, cmd;
  logic [20:0]     tick_next;
  logic            poll_req;

  assign in_word = htif_pkg::in_word_t'(s_axis_tdata);
  assign kind    = htif_pkg::kind_e'(s_axis_tuser);

  // Output register: accept a new word whenever the result slot frees up
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interactive_q <= 1'b0;
      poll_div_q    <= htif_pkg::PollDivisorReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        htif_pkg::CfgInteractive: interactive_q <= cfg_wdata_i[0];
        htif_pkg::CfgPollDivisor: poll_div_q    <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  // Access decode
  assign addr_ok  = (in_word.access_size_log2 == htif_pkg::AccessSize64) &&
                    (in_word.offset[2:0] == 3'd0);
  assign hit_to   = addr_ok && (in_word.offset == htif_pkg::TohostOffset);
  assign hit_from = addr_ok && !hit_to &&
                    (in_word.offset == htif_pkg::FromhostOffset);
  assign dev       = in_word.write_data[63:56];
  assign cmd       = in_word.write_data[55:48];
  assign tick_next = {1'b0, tick_q} + 21'd1;

  // Item processing and next state
  always_comb begin
    tohost_d   = tohost_q;
    fromhost_d = fromhost_q;
    pending_d  = pending_q;
    halted_d   = halted_q;
    tick_d     = tick_q;
    poll_req   = 1'b0;
    push       = 1'b0;
    res_d      = '0;

    unique case (kind)
      htif_pkg::KIND_READ: begin
        if (hit_to) begin
          res_d.read_data = tohost_q;
          res_d.access_ok = 1'b1;
        end else if (hit_from) begin
          res_d.read_data = fromhost_q;
          res_d.access_ok = 1'b1;
        end
      end
      htif_pkg::KIND_WRITE: begin
        if (hit_to) begin
          res_d.access_ok = 1'b1;
          tohost_d        = in_word.write_data;
          if (dev == htif_pkg::DevSystem && cmd == htif_pkg::CmdHalt &&
              in_word.write_data[0]) begin
            halted_d = 1'b1;
          end else if (dev == htif_pkg::DevConsole && cmd == htif_pkg::CmdPutchar) begin
            tohost_d             = '0;
            res_d.char_out_valid = 1'b1;
            res_d.char_out       = in_word.write_data[7:0];
            fromhost_d           = htif_pkg::PutcharAck;
          end else if (dev == htif_pkg::DevConsole && cmd == htif_pkg::CmdGetchar) begin
            tohost_d = '0;
          end
        end else if (hit_from) begin
          res_d.access_ok = 1'b1;
          fromhost_d      = in_word.write_data;
          if (interactive_q) begin
            pending_d = 1'b0;
            poll_req  = 1'b1;
          end
        end
      end
      htif_pkg::KIND_TICK: begin
        if (interactive_q) begin
          if (tick_next >= {1'b0, poll_div_q}) begin
            tick_d   = '0;
            poll_req = 1'b1;
          end else begin
            tick_d = tick_next[19:0];
          end
        end
      end
      htif_pkg::KIND_RXBYTE: begin
        if (fill_q < RxFull) begin
          push = 1'b1;
        end else begin
          res_d.rx_overflow = 1'b1;
        end
      end
      default: ;
    endcase

    // Poll: hand the head byte to fromhost when nothing is pending
    pop = poll_req && !pending_d && (fill_q != '0);
    if (pop) begin
      fromhost_d = {htif_pkg::RxMsgDev, 48'd0, head_byte_q};
      pending_d  = 1'b1;
    end

    res_d.halt_request = halted_d;
  end

  // Queue pointers
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (in_acc && pop) begin
      head_d = (head_q == RxLast) ? '0 : head_q + RxAw'(1);
      fill_d = fill_q - RxFw'(1);
    end
    if (in_acc && push) begin
      tail_d = (tail_q == RxLast) ? '0 : tail_q + RxAw'(1);
      fill_d = fill_q + RxFw'(1);
    end
  end

  // Control and mailbox registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tohost_q    <= '0;
      fromhost_q  <= '0;
      pending_q   <= 1'b0;
      halted_q    <= 1'b0;
      tick_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
    end else begin
      if (in_acc) begin
        out_valid_q <= 1'b1;
        tohost_q    <= tohost_d;
        fromhost_q  <= fromhost_d;
        pending_q   <= pending_d;
        halted_q    <= halted_d;
        tick_q      <= tick_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  // Queue memory: one write port, one read port prefetching the next head.
  // A write to the entry being fetched is forwarded into the read register.
  always_ff @(posedge clk_i) begin
    if (in_acc && push) begin
      rx_mem[tail_q] <= in_word.console_byte;
    end
    if (in_acc && push && (tail_q == head_d)) begin
      head_byte_q <= in_word.console_byte;
    end else begin
      head_byte_q <= rx_mem[head_d];
    end
  end

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= RxFull)
    else $error("receive queue fill count exceeds depth");

  // A byte becomes pending only by leaving the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(pending_q) |-> (fill_q == $past(fill_q) - RxFw'(1)))
    else $error("input became pending without a queue pop");

  // The halt flag is sticky.
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halt flag cleared");

  // A shown console character goes with a cleared tohost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && res_q.char_out_valid) |-> (tohost_q == '0))
    else $error("putchar left tohost set");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Host-target interface device testbench
// Drives bus reads and writes, time ticks and console bytes into the mailbox
// block, predicts each result word from a model of the tohost and fromhost
// registers and the console receive queue, and checks every result field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned MaxReports    = 100;
  localparam logic [7:0]  EndOfInput    = 8'd4;
  localparam logic [7:0]  CfgIndexMax   = 8'hFF;
  localparam logic [19:0] DivisorMax    = 20'hFFFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;

  // Predicted block state
  logic        interactive_q;
  logic [19:0] divisor_q;
  logic [63:0] tohost_q;
  logic [63:0] fromhost_q;
  logic        pending_q;
  logic        halted_q;
  logic [19:0] ticks_q;
  logic [7:0]  rx_fifo_q[$];

  // Result words still owed by the block, oldest first
  htif_pkg::out_word_t htif_result_q[$];

  int unsigned fail_count;
  int unsigned src_gap_pct;
  int unsigned snk_stall_pct;
  int unsigned stall_left;
  int unsigned quiet_cycles = 0;

  host_target_interface_device dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Move one queued console byte into fromhost unless a byte is still pending.
  function automatic void deliver_rx_byte();
    logic [7:0] b;
    if (!pending_q && rx_fifo_q.size() > 0) begin
      b          = rx_fifo_q.pop_front();
      fromhost_q = {htif_pkg::RxMsgDev, 48'd0, b};
      pending_q  = 1'b1;
    end
  endfunction

  // Work out the result word of one input word and advance the state.
  function automatic htif_pkg::out_word_t htif_predict(htif_pkg::kind_e k,
                                                       htif_pkg::in_word_t w);
    htif_pkg::out_word_t r;
    logic        aligned;
    logic [7:0]  dev;
    logic [7:0]  cmd;
    int unsigned next_ticks;
    r       = '0;
    aligned = (w.access_size_log2 == htif_pkg::AccessSize64) && (w.offset[2:0] == 3'd0);
    dev     = w.write_data[63:56];
    cmd     = w.write_data[55:48];
    case (k)
      htif_pkg::KIND_READ: begin
        if (aligned && w.offset == htif_pkg::TohostOffset) begin
          r.read_data = tohost_q;
          r.access_ok = 1'b1;
        end else if (aligned && w.offset == htif_pkg::FromhostOffset) begin
          r.read_data = fromhost_q;
          r.access_ok = 1'b1;
        end
      end
      htif_pkg::KIND_WRITE: begin
        if (aligned && w.offset == htif_pkg::TohostOffset) begin
          r.access_ok = 1'b1;
          tohost_q    = w.write_data;
          if (dev == htif_pkg::DevSystem && cmd == htif_pkg::CmdHalt &&
              w.write_data[0]) begin
            halted_q = 1'b1;
          end else if (dev == htif_pkg::DevConsole && cmd == htif_pkg::CmdPutchar) begin
            tohost_q         = '0;
            r.char_out_valid = 1'b1;
            r.char_out       = w.write_data[7:0];
            fromhost_q       = htif_pkg::PutcharAck;
          end else if (dev == htif_pkg::DevConsole && cmd == htif_pkg::CmdGetchar) begin
            tohost_q = '0;
          end
        end else if (aligned && w.offset == htif_pkg::FromhostOffset) begin
          r.access_ok = 1'b1;
          fromhost_q  = w.write_data;
          if (interactive_q) begin
            pending_q = 1'b0;
            deliver_rx_byte();
          end
        end
      end
      htif_pkg::KIND_TICK: begin
        // A divisor of zero or one polls on every tick.
        if (interactive_q) begin
          next_ticks = ticks_q + 1;
          if (next_ticks >= divisor_q) begin
            ticks_q = '0;
            deliver_rx_byte();
          end else begin
            ticks_q = next_ticks[19:0];
          end
        end
      end
      htif_pkg::KIND_RXBYTE: begin
        if (rx_fifo_q.size() < htif_pkg::RxDepth) begin
          rx_fifo_q.push_back(w.console_byte);
        end else begin
          r.rx_overflow = 1'b1;
        end
      end
      default: ;
    endcase
    r.halt_request = halted_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MaxReports) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
      end
    end
  endfunction

  // Result side: compare each accepted word and stall in random bursts.
  always @(posedge clk_i) begin
    htif_pkg::out_word_t want;
    htif_pkg::out_word_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = htif_pkg::out_word_t'(m_axis_tdata);
      if (htif_result_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $error("result word %0h arrived with none outstanding", m_axis_tdata);
        end
      end else begin
        want = htif_result_q.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("access_ok", 64'(want.access_ok), 64'(got.access_ok));
        check_field("halt_request", 64'(want.halt_request), 64'(got.halt_request));
        check_field("char_out_valid", 64'(want.char_out_valid), 64'(got.char_out_valid));
        check_field("char_out", 64'(want.char_out), 64'(got.char_out));
        check_field("rx_overflow", 64'(want.rx_overflow), 64'(got.rx_overflow));
        check_field("zero fill", 64'(want.pad), 64'(got.pad));
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
      stall_left = $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one input word, at times after a random idle burst, and record its result.
  task automatic send_item(htif_pkg::kind_e k, logic [11:0] off, logic [1:0] sz,
                           logic [63:0] wd, logic [7:0] cb);
    htif_pkg::in_word_t w;
    w                  = '0;
    w.offset           = off;
    w.access_size_log2 = sz;
    w.write_data       = wd;
    w.console_byte     = cb;
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    htif_result_q.push_back(htif_predict(k, w));
  endtask

  task automatic bus_read(logic [11:0] off);
    send_item(htif_pkg::KIND_READ, off, htif_pkg::AccessSize64, 64'($urandom()),
              8'($urandom()));
  endtask

  task automatic bus_write(logic [11:0] off, logic [63:0] data);
    send_item(htif_pkg::KIND_WRITE, off, htif_pkg::AccessSize64, data, 8'($urandom()));
  endtask

  task automatic tick_item();
    send_item(htif_pkg::KIND_TICK, 12'($urandom()), 2'($urandom()),
              {$urandom(), $urandom()}, 8'($urandom()));
  endtask

  task automatic rx_byte(logic [7:0] b);
    send_item(htif_pkg::KIND_RXBYTE, 12'($urandom()), 2'($urandom()),
              {$urandom(), $urandom()}, b);
  endtask

  // Stop sending and wait until every owed result word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (htif_result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == htif_pkg::CfgInteractive) begin
      interactive_q = data[0];
    end else if (idx == htif_pkg::CfgPollDivisor) begin
      divisor_q = data[19:0];
    end
  endtask

  // Rewrite both registers while the block is idle; unused bits carry junk, and
  // a write to an unused index must change nothing.
  task automatic set_config(logic inter, logic [19:0] div);
    logic [31:0] junk;
    drain_results();
    junk = $urandom();
    write_cfg(htif_pkg::CfgInteractive, {junk[31:1], inter});
    junk = $urandom();
    write_cfg(htif_pkg::CfgPollDivisor, {junk[31:20], div});
    write_cfg(8'($urandom_range(htif_pkg::CfgPollDivisor + 1, CfgIndexMax)), $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  // Random word, mostly well-formed accesses to the two registers.
  task automatic send_random_item();
    int unsigned     pick;
    htif_pkg::kind_e k;
    logic [11:0]     off;
    logic [1:0]      sz;
    logic [63:0]     wd;
    logic [7:0]      cb;
    pick = $urandom_range(0, 99);
    if (pick < 25) k = htif_pkg::KIND_READ;
    else if (pick < 50) k = htif_pkg::KIND_WRITE;
    else if (pick < 78) k = htif_pkg::KIND_TICK;
    else k = htif_pkg::KIND_RXBYTE;
    pick = $urandom_range(0, 99);
    if (pick < 45) off = htif_pkg::TohostOffset;
    else if (pick < 90) off = htif_pkg::FromhostOffset;
    else off = 12'($urandom_range(0, 4095));
    sz = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : htif_pkg::AccessSize64;
    wd = {$urandom(), $urandom()};
    cb = ($urandom_range(0, 9) == 0) ? EndOfInput : 8'($urandom_range(0, 255));
    if (k == htif_pkg::KIND_WRITE && off == htif_pkg::FromhostOffset &&
        $urandom_range(0, 1) == 0) begin
      // Acknowledge the received byte.
      wd = '0;
    end else if (k == htif_pkg::KIND_WRITE && off == htif_pkg::TohostOffset) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) wd[63:48] = {htif_pkg::DevConsole, htif_pkg::CmdPutchar};
      else if (pick < 55) wd[63:48] = {htif_pkg::DevConsole, htif_pkg::CmdGetchar};
      else if (pick < 70) wd[63:48] = {htif_pkg::DevSystem, htif_pkg::CmdHalt};
    end
    // The halt flag is sticky, so halting is left to the final test.
    if (wd[63:48] == {htif_pkg::DevSystem, htif_pkg::CmdHalt}) wd[0] = 1'b0;
    send_item(k, off, sz, wd, cb);
  endtask

  // Faults for bad size, misalignment and unknown offsets; reads after reset.
  task automatic test_register_window();
    src_gap_pct   = 30;
    snk_stall_pct = 30;
    bus_read(htif_pkg::TohostOffset);
    bus_read(htif_pkg::FromhostOffset);
    send_item(htif_pkg::KIND_READ, htif_pkg::TohostOffset, 2'd2, '0, '0);
    send_item(htif_pkg::KIND_READ, htif_pkg::TohostOffset + 12'd4,
              htif_pkg::AccessSize64, '0, '0);
    send_item(htif_pkg::KIND_READ, htif_pkg::FromhostOffset + 12'd8,
              htif_pkg::AccessSize64, '0, '0);
    send_item(htif_pkg::KIND_READ, 12'hFF8, htif_pkg::AccessSize64, '1, '1);
    send_item(htif_pkg::KIND_WRITE, htif_pkg::FromhostOffset, 2'd0, '1, '1);
    send_item(htif_pkg::KIND_WRITE, 12'hFFF, htif_pkg::AccessSize64, '1, '1);
    bus_read(htif_pkg::FromhostOffset);
  endtask

  // Unknown command, getchar, putchar and a non-halting system command.
  task automatic test_tohost_commands();
    bus_write(htif_pkg::TohostOffset, '1);
    bus_read(htif_pkg::TohostOffset);
    bus_write(htif_pkg::TohostOffset,
              {htif_pkg::DevConsole, htif_pkg::CmdGetchar, 48'h5A5A_5A5A_5A5A});
    bus_read(htif_pkg::TohostOffset);
    bus_write(htif_pkg::TohostOffset,
              {htif_pkg::DevConsole, htif_pkg::CmdPutchar, 40'hFF_FFFF_FFFF, 8'hFF});
    bus_read(htif_pkg::FromhostOffset);
    bus_write(htif_pkg::TohostOffset,
              {htif_pkg::DevSystem, htif_pkg::CmdHalt, 48'h0000_0000_0002});
    bus_read(htif_pkg::TohostOffset);
  endtask

  // Bytes queue up without polling while not interactive.
  task automatic test_console_queue();
    tick_item();
    rx_byte(8'h00);
    rx_byte(8'hFF);
    rx_byte(EndOfInput);
    bus_write(htif_pkg::FromhostOffset, {$urandom(), $urandom()});
    bus_read(htif_pkg::FromhostOffset);
  endtask

  // Filling the queue past its depth drops bytes and flags each one.
  task automatic test_rx_overflow();
    repeat (htif_pkg::RxDepth + 1) rx_byte(8'($urandom()));
  endtask

  // Polls by tick with divisors of zero and one, and by a fromhost write.
  task automatic test_console_poll();
    set_config(1'b1, 20'd0);
    tick_item();
    bus_read(htif_pkg::FromhostOffset);
    tick_item();
    bus_write(htif_pkg::FromhostOffset, '0);
    bus_read(htif_pkg::FromhostOffset);
    set_config(1'b1, 20'd1);
    tick_item();
    bus_write(htif_pkg::FromhostOffset, '0);
    tick_item();
  endtask

  // Lowering the divisor below the running count polls on the next tick.
  task automatic test_divisor_lowered();
    set_config(1'b1, 20'd20);
    while (rx_fifo_q.size() != 0) bus_write(htif_pkg::FromhostOffset, '0);
    bus_write(htif_pkg::FromhostOffset, '0);
    repeat (10) tick_item();
    rx_byte(8'h41);
    set_config(1'b1, 20'd3);
    tick_item();
    bus_read(htif_pkg::FromhostOffset);
  endtask

  task automatic run_traffic(int unsigned n, logic inter, logic [19:0] div,
                             int unsigned gap_pct, int unsigned stall_pct);
    set_config(inter, div);
    src_gap_pct   = gap_pct;
    snk_stall_pct = stall_pct;
    repeat (n) send_random_item();
  endtask

  // Halt command; the flag stays set for every later word.
  task automatic test_halt();
    bus_write(htif_pkg::TohostOffset,
              {htif_pkg::DevSystem, htif_pkg::CmdHalt, 47'($urandom()), 1'b1});
    bus_read(htif_pkg::TohostOffset);
    tick_item();
    rx_byte(8'($urandom()));
    bus_write(htif_pkg::TohostOffset,
              {htif_pkg::DevConsole, htif_pkg::CmdPutchar, 48'h0000_0000_0021});
    bus_read(htif_pkg::FromhostOffset);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = htif_pkg::KIND_READ;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = htif_pkg::CfgInteractive;
    cfg_wdata_i   = '0;
    fail_count    = 0;
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    stall_left    = 0;
    interactive_q = 1'b0;
    divisor_q     = htif_pkg::PollDivisorReset;
    tohost_q      = '0;
    fromhost_q    = '0;
    pending_q     = 1'b0;
    halted_q      = 1'b0;
    ticks_q       = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_window();
    test_tohost_commands();
    test_console_queue();
    test_rx_overflow();
    test_console_poll();
    test_divisor_lowered();
    run_traffic(200, 1'b0, htif_pkg::PollDivisorReset, 20, 20);
    run_traffic(300, 1'b1, 20'd1, 10, 40);
    run_traffic(200, 1'b1, DivisorMax, 0, 0);
    run_traffic(300, 1'b1, 20'($urandom_range(2, 16)), 40, 10);
    run_traffic(250, 1'b1, 20'd0, 25, 25);
    run_traffic(250, 1'b1, 20'd5, 0, 0);
    test_halt();
    drain_results();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== host_target_interface_device.f =====
rtl/htif_pkg.sv
rtl/host_target_interface_device.sv
sim/tb.sv
